### hdl/scm_pkg.sv
// Package for the shared cache with miss table: default sizes, beat payload
// types, function and result codes, controller state and command structs.
// No dependencies.
package scm_pkg;

    localparam int SCM_SETS         = 256;
    localparam int SCM_WAYS         = 8;
    localparam int SCM_BLOCK_BYTES  = 32;
    localparam int SCM_MISS_ENTRIES = 16;

    typedef enum logic [1:0] {
        FN_READ  = 2'd0,
        FN_WRITE = 2'd1,
        FN_FILL  = 2'd2,
        FN_NONE  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        RS_HIT       = 3'd0,
        RS_MERGED    = 3'd1,
        RS_NEW_MISS  = 3'd2,
        RS_BUSY      = 3'd3,
        RS_FILLED    = 3'd4,
        RS_UNMATCHED = 3'd5
    } result_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] address;
        logic [1:0]  core;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        mem_req_write;
        logic [31:0] mem_req_address;
        logic [1:0]  wake_core;
        logic        victim_dirty;
        logic [31:0] victim_address;
    } rsp_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK
    } state_t;

    typedef struct packed {
        logic clear;    // write zero metadata to the swept row
        logic capture;  // take the request beat, read its set
        logic look;     // resolve the access, update state, load result
    } cmd_t;

    typedef struct packed {
        logic clear_last; // sweep is at its final row
        logic rsp_busy;   // result register full and not taken this cycle
    } sts_t;

endpackage

### hdl/scm_chan_if.sv
// Valid/ready channel carrying one beat of a payload type.
// Depends on nothing; payload types come from scm_pkg at instantiation.
interface scm_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/scm_ctrl.sv
// Controller state machine: reset sweep, request acceptance, lookup step.
// Depends on scm_pkg.
module scm_ctrl
    import scm_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   req_valid,
    output logic   req_ready,
    input  sts_t   sts,
    output cmd_t   cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (sts.clear_last) state_next = S_IDLE;
            S_IDLE:  if (req_valid && !sts.rsp_busy) state_next = S_LOOK;
            S_LOOK:  state_next = S_IDLE;
            default: state_next = S_CLEAR;
        endcase
    end

    always_comb
    begin
        req_ready   = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            S_CLEAR: cmd.clear = 1'b1;
            S_IDLE:
            begin
                req_ready   = !sts.rsp_busy;
                cmd.capture = req_valid && !sts.rsp_busy;
            end
            S_LOOK:  cmd.look = 1'b1;
            default: ;
        endcase
    end

endmodule

### hdl/scm_datapath.sv
// Datapath: tag and metadata memories, miss table, lookup, replacement,
// ageing and result register.
// Depends on scm_pkg.
module scm_datapath
    import scm_pkg::*;
#(
    parameter int SETS         = SCM_SETS,
    parameter int WAYS         = SCM_WAYS,
    parameter int BLOCK_BYTES  = SCM_BLOCK_BYTES,
    parameter int MISS_ENTRIES = SCM_MISS_ENTRIES
)
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t cmd,
    output sts_t sts,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp_data
);

    localparam int OFF_W  = $clog2(BLOCK_BYTES);
    localparam int SET_W  = $clog2(SETS);
    localparam int SET_IW = (SET_W > 0) ? SET_W : 1;
    localparam int TAG_SH = OFF_W + SET_W;
    localparam int TAG_W  = 32 - TAG_SH;
    localparam int BLK_W  = 32 - OFF_W;
    localparam int AGE_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WAY_IW = AGE_W;
    localparam int ENT_IW = (MISS_ENTRIES > 1) ? $clog2(MISS_ENTRIES) : 1;
    localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(WAYS - 1);

    // set memories, one row per set
    logic [TAG_W-1:0] tag_mem   [SETS][WAYS];
    logic             valid_mem [SETS][WAYS];
    logic             dirty_mem [SETS][WAYS];
    logic [AGE_W-1:0] age_mem   [SETS][WAYS];

    logic [TAG_W-1:0] tag_rd_reg   [WAYS];
    logic             valid_rd_reg [WAYS];
    logic             dirty_rd_reg [WAYS];
    logic [AGE_W-1:0] age_rd_reg   [WAYS];

    logic [TAG_W-1:0] tag_wr   [WAYS];
    logic             valid_wr [WAYS];
    logic             dirty_wr [WAYS];
    logic [AGE_W-1:0] age_wr   [WAYS];
    logic             row_we;

    // miss table
    logic             mv_reg    [MISS_ENTRIES];
    logic [BLK_W-1:0] mblk_reg  [MISS_ENTRIES];
    logic [1:0]       mcore_reg [MISS_ENTRIES];

    logic [SET_IW-1:0] clr_cnt_reg;
    req_t              lat_reg;
    logic              rsp_valid_reg;
    rsp_t              rsp_data_reg, rsp_next;

    logic [SET_IW-1:0] set_in, set_l;
    logic [TAG_W-1:0]  tag_l;
    logic [BLK_W-1:0]  blk_l;

    logic              match_found, free_found, hit_found, inv_found;
    logic [ENT_IW-1:0] match_idx, free_idx;
    logic [WAY_IW-1:0] hit_way, inv_way, old_way, vic_way, touch_way;
    logic [AGE_W-1:0]  best_age;
    logic [AGE_W:0]    touch_ref;
    logic              do_touch, ent_alloc, ent_free;

    assign set_in = SET_IW'((req_data.address >> OFF_W) & 32'(SETS - 1));
    assign set_l  = SET_IW'((lat_reg.address >> OFF_W) & 32'(SETS - 1));
    assign tag_l  = TAG_W'(lat_reg.address >> TAG_SH);
    assign blk_l  = BLK_W'(lat_reg.address >> OFF_W);

    assign sts.clear_last = (clr_cnt_reg == SET_IW'(SETS - 1));
    assign sts.rsp_busy   = rsp_valid_reg && !rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (cmd.clear)
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            lat_reg <= req_data;
    end

    // memory write port: sweep rows after reset, else lookup update
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                valid_mem[clr_cnt_reg][w] <= 1'b0;
                dirty_mem[clr_cnt_reg][w] <= 1'b0;
                age_mem[clr_cnt_reg][w]   <= '0;
            end
        end
        else if (row_we)
        begin
            tag_mem[set_l]   <= tag_wr;
            valid_mem[set_l] <= valid_wr;
            dirty_mem[set_l] <= dirty_wr;
            age_mem[set_l]   <= age_wr;
        end
    end

    // memory read port, registered
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            tag_rd_reg   <= tag_mem[set_in];
            valid_rd_reg <= valid_mem[set_in];
            dirty_rd_reg <= dirty_mem[set_in];
            age_rd_reg   <= age_mem[set_in];
        end
    end

    // miss table search
    always_comb
    begin
        match_found = 1'b0;
        free_found  = 1'b0;
        match_idx   = '0;
        free_idx    = '0;
        for (int e = 0; e < MISS_ENTRIES; e++)
        begin
            if (mv_reg[e] && mblk_reg[e] == blk_l)
            begin
                if (!match_found)
                begin
                    match_found = 1'b1;
                    match_idx   = ENT_IW'(e);
                end
            end
            else if (!mv_reg[e] && !free_found)
            begin
                free_found = 1'b1;
                free_idx   = ENT_IW'(e);
            end
        end
    end

    // way search: hit, lowest invalid, oldest (ties to highest)
    always_comb
    begin
        hit_found = 1'b0;
        inv_found = 1'b0;
        hit_way   = '0;
        inv_way   = '0;
        old_way   = '0;
        best_age  = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (!hit_found && valid_rd_reg[w] && tag_rd_reg[w] == tag_l)
            begin
                hit_found = 1'b1;
                hit_way   = WAY_IW'(w);
            end
            if (!inv_found && !valid_rd_reg[w])
            begin
                inv_found = 1'b1;
                inv_way   = WAY_IW'(w);
            end
            if (age_rd_reg[w] >= best_age)
            begin
                best_age = age_rd_reg[w];
                old_way  = WAY_IW'(w);
            end
        end
    end

    assign vic_way = inv_found ? inv_way : old_way;

    // resolve the access
    always_comb
    begin
        rsp_next   = '0;
        row_we     = 1'b0;
        do_touch   = 1'b0;
        ent_alloc  = 1'b0;
        ent_free   = 1'b0;
        touch_way  = hit_way;
        touch_ref  = {1'b0, age_rd_reg[hit_way]};
        tag_wr     = tag_rd_reg;
        valid_wr   = valid_rd_reg;
        dirty_wr   = dirty_rd_reg;
        case (func_t'(lat_reg.func)) inside
            FN_FILL:
            begin
                if (!match_found)
                    rsp_next.status = RS_UNMATCHED;
                else
                begin
                    rsp_next.status    = RS_FILLED;
                    rsp_next.wake_core = mcore_reg[match_idx];
                    ent_free           = 1'b1;
                    row_we             = cmd.look;
                    do_touch           = 1'b1;
                    touch_way          = vic_way;
                    if (inv_found)
                        touch_ref = (AGE_W+1)'(WAYS);
                    else
                    begin
                        touch_ref = {1'b0, age_rd_reg[old_way]};
                        if (dirty_rd_reg[old_way])
                        begin
                            rsp_next.victim_dirty   = 1'b1;
                            rsp_next.victim_address =
                                (32'(tag_rd_reg[old_way]) << TAG_SH)
                                | (32'(set_l) << OFF_W);
                        end
                    end
                    tag_wr[vic_way]   = tag_l;
                    valid_wr[vic_way] = 1'b1;
                    dirty_wr[vic_way] = 1'b0;
                end
            end
            FN_READ, FN_WRITE:
            begin
                if (hit_found)
                begin
                    rsp_next.status = RS_HIT;
                    row_we          = cmd.look;
                    do_touch        = 1'b1;
                    if (lat_reg.func == FN_WRITE)
                        dirty_wr[hit_way] = 1'b1;
                end
                else if (match_found)
                    rsp_next.status = RS_MERGED;
                else if (free_found)
                begin
                    rsp_next.status          = RS_NEW_MISS;
                    rsp_next.mem_req_write   = (lat_reg.func == FN_WRITE);
                    rsp_next.mem_req_address = lat_reg.address;
                    ent_alloc                = 1'b1;
                end
                else
                    rsp_next.status = RS_BUSY;
            end
            default: ;
        endcase
    end

    // ageing relative to the reference age, touched way becomes newest
    always_comb
    begin
        for (int w = 0; w < WAYS; w++)
        begin
            age_wr[w] = age_rd_reg[w];
            if (do_touch)
            begin
                if (WAY_IW'(w) == touch_way)
                    age_wr[w] = '0;
                else if (valid_rd_reg[w] && ({1'b0, age_rd_reg[w]} < touch_ref)
                         && (age_rd_reg[w] < AGE_MAX))
                    age_wr[w] = age_rd_reg[w] + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < MISS_ENTRIES; e++)
                mv_reg[e] <= 1'b0;
        end
        else if (cmd.look)
        begin
            if (ent_free)
                mv_reg[match_idx] <= 1'b0;
            else if (ent_alloc)
                mv_reg[free_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.look && ent_alloc)
        begin
            mblk_reg[free_idx]  <= blk_l;
            mcore_reg[free_idx] <= lat_reg.core;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (cmd.look && lat_reg.func != FN_NONE)
            rsp_valid_reg <= 1'b1;
        else if (rsp_ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.look)
            rsp_data_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

### hdl/shared_cache_with_miss_table.sv
// Top level of the shared cache tag store with miss table.
// Depends on scm_pkg, scm_chan_if, scm_ctrl and scm_datapath.
//
// Use:
//   req: request beats (func, address, core). Read and write probe the set;
//        fill completes a pending miss and installs the block.
//   rsp: one result beat per request with func 0..2 (status, memory
//        request, wake core, dirty victim). Func 3 gives no beat.
// Timing:
//   A beat is taken, its set row is read from the set memory
//   into registers, and the next cycle resolves hit, miss table and
//   replacement and writes the row back (one memory port pair). The
//   result beat is registered at the end of that lookup step, and a new
//   request is taken only once the lookup of the last one is done.
// Reset:
//   Miss table valid bits clear at once; the set metadata is swept one set a
//   cycle, all SETS sets (256 by default), with req held not ready meanwhile.
// Stall:
//   The result register holds its beat until rsp is ready; a new request is
//   taken whilst that beat is being taken, and held off while it is stuck.
module shared_cache_with_miss_table
    import scm_pkg::*;
#(
    parameter int SETS         = SCM_SETS,
    parameter int WAYS         = SCM_WAYS,
    parameter int BLOCK_BYTES  = SCM_BLOCK_BYTES,
    parameter int MISS_ENTRIES = SCM_MISS_ENTRIES
)
(
    input logic           clk,
    input logic           rst_n,
    scm_chan_if.sink      req,
    scm_chan_if.source    rsp
);

    cmd_t cmd;
    sts_t sts;

    scm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    scm_datapath #(
        .SETS         (SETS),
        .WAYS         (WAYS),
        .BLOCK_BYTES  (BLOCK_BYTES),
        .MISS_ENTRIES (MISS_ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req_data  (req.data),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .rsp_data  (rsp.data)
    );

endmodule
